@@ sv/sha1_pkg.sv @@
package sha1_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } hash_t;

  typedef struct packed {
    logic       push;
    logic       shift;
    logic [7:0] data;
  } sched_ctl_t;

  localparam int unsigned Rounds = 80;
  localparam logic [6:0]  LastRound = 7'(Rounds - 1);

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam hash_t InitVector = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476,
    e: 32'hC3D2E1F0
  };

  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [5:0] BlockLast = 6'd63;

endpackage

@@ sv/sha1_hash_engine_unit.sv @@
// SHA-1 engine fed one byte per input transfer. While idle it takes a transfer
// without a stall; the transfer that completes a 64-byte block is followed by
// a stall for the 80 rounds on the single round unit and one chaining update.
// At end of message the padding and length go in one byte per cycle, paused
// for each compression (9 to 72 bytes, with one or two more compressions),
// then the five digest words leave as five output transfers, most significant
// first, and the engine returns to the initial vector.
module sha1_hash_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_FINAL = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [2:0] W_A = 3'd0;
  localparam logic [2:0] W_B = 3'd1;
  localparam logic [2:0] W_C = 3'd2;
  localparam logic [2:0] W_D = 3'd3;
  localparam logic [2:0] W_E = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [6:0]           rnd_q, rnd_d;
  logic [5:0]           fill_q, fill_d;
  logic [63:0]          len_q, len_d;
  logic                 fin_q, fin_d;
  logic                 mark_q, mark_d;
  logic                 lphase_q, lphase_d;
  logic [2:0]           oidx_q, oidx_d;
  sha1_pkg::hash_t      chain_q, chain_d;
  sha1_pkg::hash_t      work_q, work_d;
  sha1_pkg::hash_t      work_nxt;
  sha1_pkg::word_t      w_t;
  sha1_pkg::sched_ctl_t ctl;
  logic                 in_xfer;
  logic                 out_xfer;
  logic [7:0]           pad_byte;

  sha1_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .w_o   (w_t)
  );

  sha1_round u_round (
    .rnd_i (rnd_q),
    .w_i   (w_t),
    .st_i  (work_q),
    .st_o  (work_nxt)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign digest_last_o = (oidx_q == W_E);

  always_comb begin
    unique case (oidx_q)
      W_A:     digest_word_o = chain_q.a;
      W_B:     digest_word_o = chain_q.b;
      W_C:     digest_word_o = chain_q.c;
      W_D:     digest_word_o = chain_q.d;
      W_E:     digest_word_o = chain_q.e;
      default: digest_word_o = '0;
    endcase
  end

  always_comb begin
    priority if (!mark_q) begin
      pad_byte = sha1_pkg::PadMark;
    end else if (lphase_q || fill_q == sha1_pkg::LenStart) begin
      pad_byte = len_q[63:56];
    end else begin
      pad_byte = '0;
    end
  end

  always_comb begin
    state_d  = state_q;
    rnd_d    = rnd_q;
    fill_d   = fill_q;
    len_d    = len_q;
    fin_d    = fin_q;
    mark_d   = mark_q;
    lphase_d = lphase_q;
    oidx_d   = oidx_q;
    chain_d  = chain_q;
    work_d   = work_q;
    ctl      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          fin_d = end_of_message_i;
          if (byte_present_i) begin
            len_d    = len_q + 64'd8;
            ctl.push = 1'b1;
            ctl.data = data_byte_i;
            fill_d   = fill_q + 6'd1;
            if (fill_q == sha1_pkg::BlockLast) begin
              state_d = S_ROUND;
              rnd_d   = '0;
              work_d  = chain_q;
            end else if (end_of_message_i) begin
              state_d = S_PAD;
            end
          end else if (end_of_message_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_ROUND: begin
        ctl.shift = 1'b1;
        work_d    = work_nxt;
        rnd_d     = rnd_q + 7'd1;
        if (rnd_q == sha1_pkg::LastRound) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        chain_d.a = chain_q.a + work_q.a;
        chain_d.b = chain_q.b + work_q.b;
        chain_d.c = chain_q.c + work_q.c;
        chain_d.d = chain_q.d + work_q.d;
        chain_d.e = chain_q.e + work_q.e;
        priority if (lphase_q) begin
          state_d = S_OUT;
          oidx_d  = W_A;
        end else if (fin_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PAD: begin
        ctl.push = 1'b1;
        ctl.data = pad_byte;
        fill_d   = fill_q + 6'd1;
        if (!mark_q) begin
          mark_d = 1'b1;
        end else if (lphase_q || fill_q == sha1_pkg::LenStart) begin
          lphase_d = 1'b1;
          len_d    = {len_q[55:0], 8'h00};
        end
        if (fill_q == sha1_pkg::BlockLast) begin
          state_d = S_ROUND;
          rnd_d   = '0;
          work_d  = chain_q;
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          if (oidx_q == W_E) begin
            state_d  = S_IDLE;
            chain_d  = sha1_pkg::InitVector;
            fill_d   = '0;
            len_d    = '0;
            fin_d    = 1'b0;
            mark_d   = 1'b0;
            lphase_d = 1'b0;
            oidx_d   = W_A;
          end else begin
            oidx_d = oidx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rnd_q    <= '0;
      fill_q   <= '0;
      len_q    <= '0;
      fin_q    <= 1'b0;
      mark_q   <= 1'b0;
      lphase_q <= 1'b0;
      oidx_q   <= W_A;
      chain_q  <= sha1_pkg::InitVector;
      work_q   <= '0;
    end else begin
      state_q  <= state_d;
      rnd_q    <= rnd_d;
      fill_q   <= fill_d;
      len_q    <= len_d;
      fin_q    <= fin_d;
      mark_q   <= mark_d;
      lphase_q <= lphase_d;
      oidx_q   <= oidx_d;
      chain_q  <= chain_d;
      work_q   <= work_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROUND |-> rnd_q < 7'd80)
    else $error("round index out of range");

  a_out_block_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_q == '0 && lphase_q && mark_q)
    else $error("digest shown before final block");

  a_lphase_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lphase_q |-> mark_q && fin_q)
    else $error("length phase without pad mark");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && digest_last_o |=> state_q == S_IDLE && len_q == '0 && !mark_q)
    else $error("no restart after digest");
`endif

endmodule

@@ sv/sha1_round.sv @@
module sha1_round (
  input  logic [6:0]          rnd_i,
  input  sha1_pkg::word_t     w_i,
  input  sha1_pkg::hash_t     st_i,
  output sha1_pkg::hash_t     st_o
);

  sha1_pkg::word_t f;
  sha1_pkg::word_t k;
  sha1_pkg::word_t t;

  always_comb begin
    priority if (rnd_i < 7'd20) begin
      f = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
      k = sha1_pkg::K0;
    end else if (rnd_i < 7'd40) begin
      f = st_i.b ^ st_i.c ^ st_i.d;
      k = sha1_pkg::K1;
    end else if (rnd_i < 7'd60) begin
      f = (st_i.b & st_i.c) | (st_i.b & st_i.d) | (st_i.c & st_i.d);
      k = sha1_pkg::K2;
    end else begin
      f = st_i.b ^ st_i.c ^ st_i.d;
      k = sha1_pkg::K3;
    end
    t = {st_i.a[26:0], st_i.a[31:27]} + f + st_i.e + k + w_i;
    st_o.a = t;
    st_o.b = st_i.a;
    st_o.c = {st_i.b[1:0], st_i.b[31:2]};
    st_o.d = st_i.c;
    st_o.e = st_i.d;
  end

endmodule

@@ sv/sha1_sched.sv @@
module sha1_sched (
  input  logic                 clk_i,
  input  sha1_pkg::sched_ctl_t ctl_i,
  output sha1_pkg::word_t      w_o
);

  // word i of the block sits at [511-32i -: 32]
  logic [511:0]    blk_q;
  logic [511:0]    blk_d;
  sha1_pkg::word_t x;
  sha1_pkg::word_t nw;

  assign x  = blk_q[511:480] ^ blk_q[447:416] ^ blk_q[255:224] ^ blk_q[95:64];
  assign nw = {x[30:0], x[31]};
  assign w_o = blk_q[511:480];

  always_comb begin
    blk_d = blk_q;
    if (ctl_i.shift) begin
      blk_d = {blk_q[479:0], nw};
    end else if (ctl_i.push) begin
      blk_d = {blk_q[503:0], ctl_i.data};
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

endmodule
